FILE: src/principal_axis_rotation_core_assert.svh
// ---------------------------------------------------------------------------
// principal axis rotation core: assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef PRINCIPAL_AXIS_ROTATION_CORE_ASSERT_SVH
`define PRINCIPAL_AXIS_ROTATION_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PARC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define PARC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/parc_pkg.sv
// ---------------------------------------------------------------------------
// parc_pkg
// shared types, codes and the cordic arctangent table of the rotation core
// ---------------------------------------------------------------------------
package parc_pkg;

    // cordic angle word: one full turn is 2^32
    localparam int TURN_W       = 32;
    localparam int CORDIC_STEPS = 28;
    localparam int STEP_IDX_W   = $clog2(CORDIC_STEPS);
    // cordic x/y datapath, Q1.30 with headroom
    localparam int CORDIC_XY_W  = 34;
    localparam int CORDIC_FRAC  = 30;
    // start value of x: inverse cordic gain in Q1.30
    localparam logic signed [CORDIC_XY_W-1:0] CORDIC_X0 = 34'sd652032874;

    // rotation axis codes; the remaining code passes the point through
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    // quadrant of the angle, rounded to the nearest quarter turn
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // control that travels down the pipeline with each beat
    typedef struct packed {
        logic  valid;
        axis_t axis;
    } beat_ctl_t;

    // arctangent of 2^-i in 2^-32 turns
    function automatic logic [TURN_W-1:0] atan_turn(input logic [STEP_IDX_W-1:0] idx);
        logic [TURN_W-1:0] res;
        case (idx)
            5'd0:    res = 32'd536870912;
            5'd1:    res = 32'd316933406;
            5'd2:    res = 32'd167458907;
            5'd3:    res = 32'd85004756;
            5'd4:    res = 32'd42667331;
            5'd5:    res = 32'd21354465;
            5'd6:    res = 32'd10679838;
            5'd7:    res = 32'd5340245;
            5'd8:    res = 32'd2670163;
            5'd9:    res = 32'd1335087;
            5'd10:   res = 32'd667544;
            5'd11:   res = 32'd333772;
            5'd12:   res = 32'd166886;
            5'd13:   res = 32'd83443;
            5'd14:   res = 32'd41722;
            5'd15:   res = 32'd20861;
            5'd16:   res = 32'd10430;
            5'd17:   res = 32'd5215;
            5'd18:   res = 32'd2608;
            5'd19:   res = 32'd1304;
            5'd20:   res = 32'd652;
            5'd21:   res = 32'd326;
            5'd22:   res = 32'd163;
            5'd23:   res = 32'd81;
            5'd24:   res = 32'd41;
            5'd25:   res = 32'd20;
            5'd26:   res = 32'd10;
            5'd27:   res = 32'd5;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

FILE: src/parc_sincos.sv
// ---------------------------------------------------------------------------
// parc_sincos
// pipelined cordic: one rotation step per stage, quadrant fold on entry,
// quadrant map and rounding at the end; carries a sideband alongside
// ---------------------------------------------------------------------------
module parc_sincos
    import parc_pkg::*;
#(
    parameter int ANGLE_WIDTH = 16,
    parameter int TRIG_FRAC   = 30,
    parameter int SIDE_W      = 96
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  beat_ctl_t                   in_ctl,
    input  logic [SIDE_W-1:0]           in_side,
    input  logic [ANGLE_WIDTH-1:0]      angle,
    output beat_ctl_t                   out_ctl,
    output logic [SIDE_W-1:0]           out_side,
    output logic signed [TRIG_FRAC+1:0] cos_val,
    output logic signed [TRIG_FRAC+1:0] sin_val
);

    localparam int TRIG_W = TRIG_FRAC + 2;
    localparam int XY_W   = CORDIC_XY_W;
    localparam int RND_SH = CORDIC_FRAC - TRIG_FRAC;
    localparam logic [ANGLE_WIDTH-1:0] ANG_EIGHTH = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 3);
    localparam logic signed [XY_W:0] TRIG_HALF = ((XY_W + 1)'(1) << RND_SH) >> 1;

    // stage registers, index k holds the state before cordic step k
    beat_ctl_t                ctl_reg  [0:CORDIC_STEPS];
    logic [SIDE_W-1:0]        side_reg [0:CORDIC_STEPS];
    quad_t                    quad_reg [0:CORDIC_STEPS];
    logic signed [XY_W-1:0]   x_reg    [0:CORDIC_STEPS];
    logic signed [XY_W-1:0]   y_reg    [0:CORDIC_STEPS];
    logic signed [TURN_W-1:0] z_reg    [0:CORDIC_STEPS];

    logic [ANGLE_WIDTH-1:0]   ang_bias;
    logic [ANGLE_WIDTH-1:0]   ang_resid;
    quad_t                    quad_next;
    logic signed [TURN_W-1:0] z_next;

    beat_ctl_t                map_ctl_reg;
    logic [SIDE_W-1:0]        map_side_reg;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] cos_next;
    logic signed [TRIG_W-1:0] sin_next;
    logic signed [XY_W-1:0]   c_map;
    logic signed [XY_W-1:0]   s_map;
    logic signed [XY_W:0]     c_wide;
    logic signed [XY_W:0]     s_wide;

    // quadrant fold: residual within an eighth of a turn either side
    always_comb
    begin
        ang_bias  = angle + ANG_EIGHTH;
        quad_next = quad_t'(ang_bias[ANGLE_WIDTH-1 -: 2]);
        ang_resid = angle - {ang_bias[ANGLE_WIDTH-1 -: 2], {(ANGLE_WIDTH - 2){1'b0}}};
        z_next    = {ang_resid, {(TURN_W - ANGLE_WIDTH){1'b0}}};
    end

    // entry stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else if (en)
        begin
            ctl_reg[0] <= in_ctl;
        end
    end

    // entry stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            quad_reg[0] <= quad_next;
            x_reg[0]    <= CORDIC_X0;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_next;
        end
    end

    // one cordic micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam logic signed [TURN_W-1:0] ATAN_I = atan_turn(STEP_IDX_W'(i));

        logic signed [XY_W-1:0]   dx;
        logic signed [XY_W-1:0]   dy;
        logic signed [XY_W-1:0]   x_next;
        logic signed [XY_W-1:0]   y_next;
        logic signed [TURN_W-1:0] zs_next;

        always_comb
        begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            if (!z_reg[i][TURN_W-1])
            begin
                x_next  = x_reg[i] - dx;
                y_next  = y_reg[i] + dy;
                zs_next = z_reg[i] - ATAN_I;
            end
            else
            begin
                x_next  = x_reg[i] + dx;
                y_next  = y_reg[i] - dy;
                zs_next = z_reg[i] + ATAN_I;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[i+1] <= '0;
            end
            else if (en)
            begin
                ctl_reg[i+1] <= ctl_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i+1] <= side_reg[i];
                quad_reg[i+1] <= quad_reg[i];
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= zs_next;
            end
        end
    end

    // quadrant map and rounding to the trig precision
    always_comb
    begin
        case (quad_reg[CORDIC_STEPS])
            QUAD_1:
            begin
                c_map = -y_reg[CORDIC_STEPS];
                s_map = x_reg[CORDIC_STEPS];
            end
            QUAD_2:
            begin
                c_map = -x_reg[CORDIC_STEPS];
                s_map = -y_reg[CORDIC_STEPS];
            end
            QUAD_3:
            begin
                c_map = y_reg[CORDIC_STEPS];
                s_map = -x_reg[CORDIC_STEPS];
            end
            default:
            begin
                c_map = x_reg[CORDIC_STEPS];
                s_map = y_reg[CORDIC_STEPS];
            end
        endcase
        c_wide   = (XY_W + 1)'(c_map) + TRIG_HALF;
        s_wide   = (XY_W + 1)'(s_map) + TRIG_HALF;
        cos_next = TRIG_W'(c_wide >>> RND_SH);
        sin_next = TRIG_W'(s_wide >>> RND_SH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_ctl_reg <= '0;
        end
        else if (en)
        begin
            map_ctl_reg <= ctl_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            map_side_reg <= side_reg[CORDIC_STEPS];
            cos_reg      <= cos_next;
            sin_reg      <= sin_next;
        end
    end

    assign out_ctl  = map_ctl_reg;
    assign out_side = map_side_reg;
    assign cos_val  = cos_reg;
    assign sin_val  = sin_reg;

endmodule

FILE: src/parc_rotate.sv
// ---------------------------------------------------------------------------
// parc_rotate
// plane rotation of the selected coordinate pair: multiply stage, sum and
// round stage, saturate and axis select stage
// ---------------------------------------------------------------------------
module parc_rotate
    import parc_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int TRIG_FRAC   = 30
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  beat_ctl_t                     in_ctl,
    input  logic signed [COORD_WIDTH-1:0] in_x,
    input  logic signed [COORD_WIDTH-1:0] in_y,
    input  logic signed [COORD_WIDTH-1:0] in_z,
    input  logic signed [TRIG_FRAC+1:0]   cos_val,
    input  logic signed [TRIG_FRAC+1:0]   sin_val,
    output logic                          out_valid,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic signed [COORD_WIDTH-1:0] out_z,
    output logic                          out_sat
);

    localparam int TRIG_W = TRIG_FRAC + 2;
    localparam int PROD_W = COORD_WIDTH + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SH_W   = SUM_W - TRIG_FRAC;
    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (TRIG_FRAC - 1);
    localparam logic signed [SH_W-1:0]  SAT_MAX  = {4'b0000, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [SH_W-1:0]  SAT_MIN  = {4'b1111, {(COORD_WIDTH - 1){1'b0}}};

    // multiply stage
    logic signed [COORD_WIDTH-1:0] a_sel;
    logic signed [COORD_WIDTH-1:0] b_sel;
    logic signed [PROD_W-1:0]      prod_ac_next;
    logic signed [PROD_W-1:0]      prod_bs_next;
    logic signed [PROD_W-1:0]      prod_as_next;
    logic signed [PROD_W-1:0]      prod_bc_next;
    beat_ctl_t                     mul_ctl_reg;
    logic signed [PROD_W-1:0]      prod_ac_reg;
    logic signed [PROD_W-1:0]      prod_bs_reg;
    logic signed [PROD_W-1:0]      prod_as_reg;
    logic signed [PROD_W-1:0]      prod_bc_reg;
    logic signed [COORD_WIDTH-1:0] mul_x_reg;
    logic signed [COORD_WIDTH-1:0] mul_y_reg;
    logic signed [COORD_WIDTH-1:0] mul_z_reg;

    // sum stage
    logic signed [SUM_W-1:0]       sum_p_next;
    logic signed [SUM_W-1:0]       sum_q_next;
    beat_ctl_t                     sum_ctl_reg;
    logic signed [SUM_W-1:0]       sum_p_reg;
    logic signed [SUM_W-1:0]       sum_q_reg;
    logic signed [COORD_WIDTH-1:0] sum_x_reg;
    logic signed [COORD_WIDTH-1:0] sum_y_reg;
    logic signed [COORD_WIDTH-1:0] sum_z_reg;

    // saturate stage
    logic signed [SH_W-1:0]        rot_p;
    logic signed [SH_W-1:0]        rot_q;
    logic signed [COORD_WIDTH-1:0] sat_p;
    logic signed [COORD_WIDTH-1:0] sat_q;
    logic                          clip_p;
    logic                          clip_q;
    logic signed [COORD_WIDTH-1:0] res_x_next;
    logic signed [COORD_WIDTH-1:0] res_y_next;
    logic signed [COORD_WIDTH-1:0] res_z_next;
    logic                          res_sat_next;
    logic                          res_valid_reg;
    logic signed [COORD_WIDTH-1:0] res_x_reg;
    logic signed [COORD_WIDTH-1:0] res_y_reg;
    logic signed [COORD_WIDTH-1:0] res_z_reg;
    logic                          res_sat_reg;

    // pick the rotation plane and form the four products
    always_comb
    begin
        case (in_ctl.axis)
            AXIS_X:
            begin
                a_sel = in_y;
                b_sel = in_z;
            end
            AXIS_Y:
            begin
                a_sel = in_x;
                b_sel = in_z;
            end
            default:
            begin
                a_sel = in_x;
                b_sel = in_y;
            end
        endcase
        prod_ac_next = PROD_W'(a_sel * cos_val);
        prod_bs_next = PROD_W'(b_sel * sin_val);
        prod_as_next = PROD_W'(a_sel * sin_val);
        prod_bc_next = PROD_W'(b_sel * cos_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_ctl_reg <= '0;
        end
        else if (en)
        begin
            mul_ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_ac_reg <= prod_ac_next;
            prod_bs_reg <= prod_bs_next;
            prod_as_reg <= prod_as_next;
            prod_bc_reg <= prod_bc_next;
            mul_x_reg   <= in_x;
            mul_y_reg   <= in_y;
            mul_z_reg   <= in_z;
        end
    end

    // both rotated terms with the rounding half added
    always_comb
    begin
        sum_p_next = SUM_W'(prod_ac_reg) - SUM_W'(prod_bs_reg) + RND_HALF;
        sum_q_next = SUM_W'(prod_as_reg) + SUM_W'(prod_bc_reg) + RND_HALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_ctl_reg <= '0;
        end
        else if (en)
        begin
            sum_ctl_reg <= mul_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_p_reg <= sum_p_next;
            sum_q_reg <= sum_q_next;
            sum_x_reg <= mul_x_reg;
            sum_y_reg <= mul_y_reg;
            sum_z_reg <= mul_z_reg;
        end
    end

    // drop the trig fraction, clamp, and route back to the axes
    always_comb
    begin
        rot_p  = sum_p_reg[SUM_W-1:TRIG_FRAC];
        rot_q  = sum_q_reg[SUM_W-1:TRIG_FRAC];
        clip_p = (rot_p > SAT_MAX) || (rot_p < SAT_MIN);
        clip_q = (rot_q > SAT_MAX) || (rot_q < SAT_MIN);
        if (rot_p > SAT_MAX)
        begin
            sat_p = SAT_MAX[COORD_WIDTH-1:0];
        end
        else if (rot_p < SAT_MIN)
        begin
            sat_p = SAT_MIN[COORD_WIDTH-1:0];
        end
        else
        begin
            sat_p = rot_p[COORD_WIDTH-1:0];
        end
        if (rot_q > SAT_MAX)
        begin
            sat_q = SAT_MAX[COORD_WIDTH-1:0];
        end
        else if (rot_q < SAT_MIN)
        begin
            sat_q = SAT_MIN[COORD_WIDTH-1:0];
        end
        else
        begin
            sat_q = rot_q[COORD_WIDTH-1:0];
        end

        res_x_next   = sum_x_reg;
        res_y_next   = sum_y_reg;
        res_z_next   = sum_z_reg;
        res_sat_next = clip_p | clip_q;
        case (sum_ctl_reg.axis)
            AXIS_X:
            begin
                res_y_next = sat_p;
                res_z_next = sat_q;
            end
            AXIS_Y:
            begin
                res_x_next = sat_p;
                res_z_next = sat_q;
            end
            AXIS_Z:
            begin
                res_x_next = sat_p;
                res_y_next = sat_q;
            end
            default:
            begin
                // unused axis code: point passes through untouched
                res_sat_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= sum_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_x_reg   <= res_x_next;
            res_y_reg   <= res_y_next;
            res_z_reg   <= res_z_next;
            res_sat_reg <= res_sat_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_x     = res_x_reg;
    assign out_y     = res_y_reg;
    assign out_z     = res_z_reg;
    assign out_sat   = res_sat_reg;

endmodule

FILE: src/parc_skid.sv
// ---------------------------------------------------------------------------
// parc_skid
// output register with one skid entry; the upstream hold is registered so
// the output stall never reaches the pipeline combinationally
// ---------------------------------------------------------------------------
module parc_skid
#(
    parameter int DATA_W = 97
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    input  logic [DATA_W-1:0] up_data,
    output logic              up_hold,
    output logic              valid,
    input  logic              stall,
    output logic [DATA_W-1:0] data
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    logic [DATA_W-1:0] skid_data_reg;
    logic              load_up;
    logic              load_skid;
    logic              take_skid;

    // occupancy of the output and skid entries
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_up         = 1'b0;
        load_skid       = 1'b0;
        take_skid       = 1'b0;
        if (!out_valid_reg || !stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
                take_skid       = 1'b1;
            end
            else
            begin
                out_valid_next = up_valid;
                load_up        = up_valid;
            end
        end
        else if (up_valid && !skid_valid_reg)
        begin
            skid_valid_next = 1'b1;
            load_skid       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload moves
    always_ff @(posedge clk)
    begin
        if (take_skid)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (load_up)
        begin
            out_data_reg <= up_data;
        end
        if (load_skid)
        begin
            skid_data_reg <= up_data;
        end
    end

    assign up_hold = skid_valid_reg;
    assign valid   = out_valid_reg;
    assign data    = out_data_reg;

endmodule

FILE: src/principal_axis_rotation_core.sv
// ---------------------------------------------------------------------------
// principal_axis_rotation_core
// rotates a signed fixed-point 3d point about the x, y or z axis by a
// binary angle, with saturation of the rotated pair
// ---------------------------------------------------------------------------
//  channel | handshake              | beat contents
//  --------+------------------------+------------------------------------
//  input   | in_valid / in_stall    | func, in_x, in_y, in_z, angle
//  output  | out_valid / out_stall  | out_x, out_y, out_z, saturated
//
//  one beat per clock in and out unless stalled; each beat passes through
//  30 cordic stages (entry, 28 steps, quadrant map), 3 rotation stages
//  (multiply, sum, saturate) and the output register
//  rst_n clears all valid bits asynchronously; no configuration, no state
//  out_stall is absorbed by a one-entry skid; in_stall rises only once the
//  skid is full and the whole pipeline then holds in place
// ---------------------------------------------------------------------------
`include "principal_axis_rotation_core_assert.svh"

module principal_axis_rotation_core
    import parc_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    func,
    input  logic signed [COORD_WIDTH-1:0] in_x,
    input  logic signed [COORD_WIDTH-1:0] in_y,
    input  logic signed [COORD_WIDTH-1:0] in_z,
    input  logic [ANGLE_WIDTH-1:0]        angle,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic signed [COORD_WIDTH-1:0] out_z,
    output logic                          saturated
);

    localparam int TRIG_FRAC = (COORD_WIDTH <= 32) ? 30 : 62 - COORD_WIDTH;
    localparam int TRIG_W    = TRIG_FRAC + 2;
    localparam int SIDE_W    = 3 * COORD_WIDTH;
    localparam int RES_W     = 3 * COORD_WIDTH + 1;

    logic                          hold;
    logic                          pipe_en;
    beat_ctl_t                     entry_ctl;
    beat_ctl_t                     trig_ctl;
    logic [SIDE_W-1:0]             trig_side;
    logic signed [TRIG_W-1:0]      cos_val;
    logic signed [TRIG_W-1:0]      sin_val;
    logic                          rot_valid;
    logic signed [COORD_WIDTH-1:0] rot_x;
    logic signed [COORD_WIDTH-1:0] rot_y;
    logic signed [COORD_WIDTH-1:0] rot_z;
    logic                          rot_sat;
    logic [RES_W-1:0]              res_data;

    // whole pipeline advances unless the skid entry is occupied
    assign pipe_en   = !hold;
    assign in_stall  = hold;
    assign entry_ctl = '{valid: in_valid, axis: axis_t'(func)};

    // sine and cosine, coordinates ride alongside
    parc_sincos #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .TRIG_FRAC   (TRIG_FRAC),
        .SIDE_W      (SIDE_W)
    ) u_sincos (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_ctl   (entry_ctl),
        .in_side  ({in_x, in_y, in_z}),
        .angle    (angle),
        .out_ctl  (trig_ctl),
        .out_side (trig_side),
        .cos_val  (cos_val),
        .sin_val  (sin_val)
    );

    // plane rotation and saturation
    parc_rotate #(
        .COORD_WIDTH (COORD_WIDTH),
        .TRIG_FRAC   (TRIG_FRAC)
    ) u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_ctl    (trig_ctl),
        .in_x      (trig_side[3*COORD_WIDTH-1:2*COORD_WIDTH]),
        .in_y      (trig_side[2*COORD_WIDTH-1:COORD_WIDTH]),
        .in_z      (trig_side[COORD_WIDTH-1:0]),
        .cos_val   (cos_val),
        .sin_val   (sin_val),
        .out_valid (rot_valid),
        .out_x     (rot_x),
        .out_y     (rot_y),
        .out_z     (rot_z),
        .out_sat   (rot_sat)
    );

    // output register and skid
    parc_skid #(
        .DATA_W (RES_W)
    ) u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (rot_valid),
        .up_data  ({rot_x, rot_y, rot_z, rot_sat}),
        .up_hold  (hold),
        .valid    (out_valid),
        .stall    (out_stall),
        .data     (res_data)
    );

    assign out_x     = res_data[RES_W-1 -: COORD_WIDTH];
    assign out_y     = res_data[2*COORD_WIDTH:COORD_WIDTH+1];
    assign out_z     = res_data[COORD_WIDTH:1];
    assign saturated = res_data[0];

    // a held pipeline always has a result waiting at the output
    `PARC_ASSERT_NOW(a_hold_has_output, hold, out_valid, "pipeline held with empty output")
    // skid fills only when the output is occupied and stalled
    `PARC_ASSERT_NOW(a_skid_fill, $rose(hold), $past(out_valid && out_stall),
        "skid filled while output was free")
    // skid drains only when the output beat is taken
    `PARC_ASSERT_NOW(a_skid_drain, $fell(hold), $past(!out_stall),
        "skid drained while output stalled")
    // a drained skid refills the output in the next cycle
    `PARC_ASSERT_NEXT(a_skid_refill, out_valid && !out_stall && hold, out_valid,
        "skid beat lost after output handover")

endmodule

FILE: tb/rotation_checker.sv
// ---------------------------------------------------------------------------
// rotation_checker
// watches both channels of the axis rotation core, works out the rotated
// point of every accepted input beat with its own cordic and saturation
// arithmetic, and compares each output beat field by field in order
// ---------------------------------------------------------------------------
module rotation_checker
    import parc_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [1:0]             func,
    input  logic [COORD_WIDTH-1:0] in_x,
    input  logic [COORD_WIDTH-1:0] in_y,
    input  logic [COORD_WIDTH-1:0] in_z,
    input  logic [ANGLE_WIDTH-1:0] angle,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [COORD_WIDTH-1:0] out_x,
    input  logic [COORD_WIDTH-1:0] out_y,
    input  logic [COORD_WIDTH-1:0] out_z,
    input  logic                   saturated,
    output int                     mismatches,
    output int                     pending
);

    localparam int     TURN_BITS   = 32;
    localparam int     SWEEP_STEPS = 28;
    localparam int     TRIG_FRAC   = (COORD_WIDTH <= 32) ? 30 : 62 - COORD_WIDTH;
    localparam longint GAIN_START  = 64'sd652032874;
    localparam longint COORD_TOP   = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_BOT   = -(longint'(1) <<< (COORD_WIDTH - 1));
    localparam int     SHOW_LIMIT  = 10;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic [COORD_WIDTH-1:0] z;
        logic                   sat;
    } point_t;

    // arctangent of 2^-i in 2^-32 turns
    longint arctan_turns [SWEEP_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};

    point_t expected_points [$];
    int     fail_count = 0;
    int     waiting    = 0;

    assign mismatches = fail_count;
    assign pending    = waiting;

    // add half, then floor shift
    function automatic longint round_off(input longint v, input int s);
        if (s == 0)
            return v;
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // cosine and sine of a binary angle, Q1.TRIG_FRAC
    function automatic void trig_pair(input logic [ANGLE_WIDTH-1:0] ang,
                                      output longint cosv, output longint sinv);
        logic [TURN_BITS-1:0]        turn;
        logic [TURN_BITS-1:0]        biased;
        logic signed [TURN_BITS-1:0] resid;
        quad_t                       quad;
        longint                      cx, cy, cz, dx, dy, c, s;
        turn   = TURN_BITS'(ang) << (TURN_BITS - ANGLE_WIDTH);
        biased = turn + 32'h2000_0000;
        quad   = quad_t'(biased[TURN_BITS-1 -: 2]);
        resid  = turn - {biased[TURN_BITS-1 -: 2], 30'd0};
        cx = GAIN_START;
        cy = 0;
        cz = resid;
        for (int i = 0; i < SWEEP_STEPS; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0)
            begin
                cx -= dx;
                cy += dy;
                cz -= arctan_turns[i];
            end
            else
            begin
                cx += dx;
                cy -= dy;
                cz += arctan_turns[i];
            end
        end
        case (quad)
            QUAD_1:
            begin
                c = -cy;
                s = cx;
            end
            QUAD_2:
            begin
                c = -cx;
                s = -cy;
            end
            QUAD_3:
            begin
                c = cy;
                s = -cx;
            end
            default:
            begin
                c = cx;
                s = cy;
            end
        endcase
        cosv = round_off(c, 30 - TRIG_FRAC);
        sinv = round_off(s, 30 - TRIG_FRAC);
    endfunction

    // a*p - b*q, rounded back to coordinate scale and clamped
    function automatic longint rotate_term(input longint a, input longint b,
                                           input longint p, input longint q,
                                           inout logic clamped);
        longint v;
        v = round_off(a * p - b * q, TRIG_FRAC);
        if (v > COORD_TOP)
        begin
            clamped = 1'b1;
            return COORD_TOP;
        end
        if (v < COORD_BOT)
        begin
            clamped = 1'b1;
            return COORD_BOT;
        end
        return v;
    endfunction

    // rotated point of one input beat
    function automatic point_t predict_rotation(input logic [1:0] code,
                                                input logic signed [COORD_WIDTH-1:0] x,
                                                input logic signed [COORD_WIDTH-1:0] y,
                                                input logic signed [COORD_WIDTH-1:0] z,
                                                input logic [ANGLE_WIDTH-1:0] ang);
        longint ox, oy, oz, c, s;
        logic   clamped;
        point_t res;
        ox = x;
        oy = y;
        oz = z;
        clamped = 1'b0;
        trig_pair(ang, c, s);
        case (axis_t'(code))
            AXIS_X:
            begin
                oy = rotate_term(y, z, c, s, clamped);
                oz = rotate_term(y, z, s, -c, clamped);
            end
            AXIS_Y:
            begin
                ox = rotate_term(x, z, c, s, clamped);
                oz = rotate_term(x, z, s, -c, clamped);
            end
            AXIS_Z:
            begin
                ox = rotate_term(x, y, c, s, clamped);
                oy = rotate_term(x, y, s, -c, clamped);
            end
            default:
            begin
                // unused axis code: point passes through untouched
            end
        endcase
        res.x   = ox[COORD_WIDTH-1:0];
        res.y   = oy[COORD_WIDTH-1:0];
        res.z   = oz[COORD_WIDTH-1:0];
        res.sat = clamped;
        return res;
    endfunction

    // log each beat in, compare each beat out against the oldest prediction
    always @(posedge clk)
    begin : watch
        point_t want;
        point_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_points.push_back(predict_rotation(func, in_x, in_y, in_z, angle));
            if (out_valid && !out_stall)
            begin
                got = {out_x, out_y, out_z, saturated};
                if (expected_points.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= SHOW_LIMIT)
                        $display("rotation_checker: unexpected beat x=%0d y=%0d z=%0d sat=%0b",
                                 $signed(got.x), $signed(got.y), $signed(got.z), got.sat);
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.z !== want.z
                        || got.sat !== want.sat)
                    begin
                        fail_count++;
                        if (fail_count <= SHOW_LIMIT)
                        begin
                            $display("rotation_checker: mismatch at %0t", $realtime);
                            $display("  expected x=%0d y=%0d z=%0d sat=%0b",
                                     $signed(want.x), $signed(want.y), $signed(want.z),
                                     want.sat);
                            $display("  actual   x=%0d y=%0d z=%0d sat=%0b",
                                     $signed(got.x), $signed(got.y), $signed(got.z),
                                     got.sat);
                        end
                    end
                end
            end
            waiting = expected_points.size();
        end
    end

endmodule

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// drives the axis rotation core with a directed set of extreme points and
// angles, then random points with random gaps on the input and random
// stalls on the output; the checker alongside predicts and compares
// ---------------------------------------------------------------------------
module testbench;

    import parc_pkg::*;

    localparam int          CW           = 32;
    localparam int          AW           = 16;
    localparam int          RANDOM_BEATS = 1950;
    localparam int          SETTLE       = 40;
    localparam logic [31:0] COORD_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] COORD_MIN    = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
    localparam logic [31:0] UNIT         = 32'h0001_0000;
    localparam logic [31:0] HALF_UNIT    = 32'h0000_8000;
    localparam logic [15:0] EIGHTH_TURN  = 16'h2000;
    localparam logic [15:0] QUARTER_TURN = 16'h4000;
    localparam logic [15:0] HALF_TURN    = 16'h8000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 out_stall = 1'b0;
    logic [1:0]           func      = '0;
    logic signed [CW-1:0] in_x      = '0;
    logic signed [CW-1:0] in_y      = '0;
    logic signed [CW-1:0] in_z      = '0;
    logic [AW-1:0]        angle     = '0;
    logic                 in_stall;
    logic                 out_valid;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic                 saturated;
    int                   mismatches;
    int                   pending;

    principal_axis_rotation_core #(
        .COORD_WIDTH (CW),
        .ANGLE_WIDTH (AW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .angle     (angle),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .saturated (saturated)
    );

    rotation_checker #(
        .COORD_WIDTH (CW),
        .ANGLE_WIDTH (AW)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .in_x       (in_x),
        .in_y       (in_y),
        .in_z       (in_z),
        .angle      (angle),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z),
        .saturated  (saturated),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // present one beat and hold it until accepted
    task automatic send_point(input logic [1:0] code, input logic [31:0] x,
                              input logic [31:0] y, input logic [31:0] z,
                              input logic [15:0] ang);
        in_valid <= 1'b1;
        func     <= code;
        in_x     <= x;
        in_y     <= y;
        in_z     <= z;
        angle    <= ang;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // drop valid for a number of cycles
    task automatic pause_input(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // drop valid and let every outstanding beat come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // coordinate: full range, small, medium or an extreme
    function automatic logic [31:0] random_coord();
        logic [19:0] narrow;
        logic [27:0] mid;
        narrow = $urandom();
        mid    = $urandom();
        case ($urandom_range(0, 5))
            2, 3:    return {{12{narrow[19]}}, narrow};
            4:       return {{4{mid[27]}}, mid};
            5:
            begin
                case ($urandom_range(0, 3))
                    0:       return COORD_MAX;
                    1:       return COORD_MIN;
                    2:       return ALL_ONES;
                    default: return '0;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // angle: mostly random, some near quadrant boundaries or quarter turns
    function automatic logic [15:0] random_angle();
        logic [15:0] base;
        base = 16'($urandom_range(0, 3)) * QUARTER_TURN;
        case ($urandom_range(0, 5))
            4:       return base + EIGHTH_TURN + 16'($urandom_range(0, 4)) - 16'd2;
            5:       return base + 16'($urandom_range(0, 2)) - 16'd1;
            default: return $urandom();
        endcase
    endfunction

    // input gap: some bursts with none, else mostly none or short, a few long
    function automatic int sender_gap(input int idx);
        int roll;
        roll = $urandom_range(0, 99);
        if ((idx % 300) < 60 || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // output stall: free runs and stalls, mostly short, now and then a long one
    initial
    begin : stall_driver
        int run;
        @(posedge clk);
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 6);
            repeat (run) @(posedge clk);
            out_stall <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
            repeat (run) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every axis code with saturating and pass-through extremes
        for (int f = 0; f < 4; f++)
        begin
            send_point(2'(f), COORD_MAX, COORD_MAX, COORD_MAX, EIGHTH_TURN);
            send_point(2'(f), COORD_MIN, COORD_MIN, COORD_MIN, EIGHTH_TURN);
            send_point(2'(f), UNIT, -UNIT, COORD_MIN, QUARTER_TURN);
        end
        // negating the most negative coordinate clamps
        send_point(AXIS_Y, COORD_MIN, '0, '0, HALF_TURN);
        send_point(AXIS_X, '0, '0, '0, 16'hFFFF);
        send_point(AXIS_Z, ALL_ONES, ALL_ONES, ALL_ONES, HALF_TURN);
        // angles across quadrant boundaries
        send_point(AXIS_Z, UNIT, HALF_UNIT, -UNIT, 16'h0000);
        send_point(AXIS_Z, UNIT, HALF_UNIT, -UNIT, EIGHTH_TURN - 16'd1);
        send_point(AXIS_Z, UNIT, HALF_UNIT, -UNIT, EIGHTH_TURN);
        send_point(AXIS_Z, UNIT, HALF_UNIT, -UNIT, 16'h6000);
        send_point(AXIS_Z, UNIT, HALF_UNIT, -UNIT, HALF_TURN);
        send_point(AXIS_Z, UNIT, HALF_UNIT, -UNIT, 16'hA000);
        send_point(AXIS_Z, UNIT, HALF_UNIT, -UNIT, 16'hC000);
        send_point(AXIS_Z, UNIT, HALF_UNIT, -UNIT, 16'hE000);
        send_point(AXIS_Z, UNIT, HALF_UNIT, -UNIT, 16'hFFFF);
        drain_results();

        // random points
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == RANDOM_BEATS / 2)
                drain_results();
            else
                pause_input(sender_gap(n));
            send_point(2'($urandom_range(0, 3)), random_coord(), random_coord(),
                       random_coord(), random_angle());
        end
        in_valid <= 1'b0;

        // wait for the last beats and a quiet tail
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/parc_pkg.sv
src/parc_sincos.sv
src/parc_rotate.sv
src/parc_skid.sv
src/principal_axis_rotation_core.sv
tb/rotation_checker.sv
tb/testbench.sv
